FILE: hw/rtl/lcdq_pkg.sv
// shared types and constants of the lcd nibble command queue
`default_nettype none

package lcdq_pkg;

  // operation codes of an input beat
  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_DONE    = 3'd1;
  localparam logic [2:0] OP_PAUSE   = 3'd2;
  localparam logic [2:0] OP_RESUME  = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_ABORT   = 3'd5;

  // status codes of a result beat
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_PAUSED_FULL = 3'd2;
  localparam logic [2:0] ST_TIMEOUT     = 3'd3;
  localparam logic [2:0] ST_BUS_ERROR   = 3'd4;
  localparam logic [2:0] ST_START_FAIL  = 3'd5;
  localparam logic [2:0] ST_HELD        = 3'd6;
  localparam logic [2:0] ST_BUSY        = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

  // reset values of the configuration registers
  localparam logic       BACKLIGHT_RST = 1'b1;
  localparam logic [7:0] TIMEOUT_RST   = 8'd10;

  // expander byte framing
  localparam logic [7:0] NIB_HI_MASK = 8'hf0;
  localparam logic [7:0] EN_FLAG     = 8'h04;
  localparam logic [7:0] BL_FLAG     = 8'h08;
  localparam logic [7:0] RS_FLAG     = 8'h01;

  // one stored entry: select bit over the byte
  localparam int unsigned ENTRY_W = 9;

  typedef struct packed {
    logic [2:0] op;
    logic       reg_select;
    logic [7:0] entry_byte;
    logic       start_flush;
    logic       bus_error;
    logic       link_refuses;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       tx_start;
    logic [7:0] byte_hi_setup;
    logic [7:0] byte_hi_strobe;
    logic [7:0] byte_hi_hold;
    logic [7:0] byte_lo_setup;
    logic [7:0] byte_lo_strobe;
    logic [7:0] byte_lo_hold;
    logic       queue_full;
    logic       paused_while_flushing;
    logic       flushing;
    logic [5:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic       backlight_on;
    logic [7:0] full_timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lcd_nibble_command_queue.sv
// top level of the lcd nibble command queue
`default_nettype none

// Command queue for a character display driven through a 4-bit expander.
// Entries (select bit and byte) sit in a ring store of QUEUE_DEPTH entries;
// each transfer takes the head entry out and reports it as six expander bytes,
// high nibble then low nibble, each as setup, strobe and hold. Every input
// beat gives exactly one result beat. An input beat runs in two steps: at
// acceptance the head entry is read from the store into a register, and then the
// queue state is updated and the result is loaded into the output register,
// which frees the input side while the result waits to be taken. An output
// register that is still held by stall delays the update step. Configuration
// writes are always ready and are to be issued only while the block is idle.
module lcd_nibble_command_queue
  import lcdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire in_item_t             in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      out_item_t            out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t               cfg_r, cfg_nxt;
  logic               exec_valid_r, exec_valid_nxt;
  in_item_t           item_r;
  logic               in_accept;
  logic               consume;
  logic [PTR_W-1:0]   rd_ptr;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] head_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = exec_valid_r;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BACKLIGHT: cfg_nxt.backlight_on       = cfg_data[0];
        CFG_TIMEOUT:   cfg_nxt.full_timeout_ticks = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input beat holding stage
  always_comb begin
    exec_valid_nxt = exec_valid_r;
    if (in_accept) begin
      exec_valid_nxt = 1'b1;
    end else if (consume) begin
      exec_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backlight_on       <= BACKLIGHT_RST;
      cfg_r.full_timeout_ticks <= TIMEOUT_RST;
      exec_valid_r             <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      exec_valid_r <= exec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  lcdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (rd_ptr),
    .rdata (head_rdata)
  );

  lcdq_engine #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .exec_valid (exec_valid_r),
    .item       (item_r),
    .head_rdata (head_rdata),
    .rd_ptr     (rd_ptr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .consume    (consume),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lcdq_store.sv
// entry store: one write port, one registered read port
`default_nettype none

module lcdq_store
  import lcdq_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned PTR_W = 5
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [PTR_W-1:0]   waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [PTR_W-1:0]   raddr,
  output      logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lcdq_engine.sv
// queue state update, nibble framing and result register
`default_nettype none

module lcdq_engine
  import lcdq_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned PTR_W = 5,
  parameter int unsigned CNT_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               exec_valid,
  input  wire in_item_t           item,
  input  wire logic [ENTRY_W-1:0] head_rdata,
  output      logic [PTR_W-1:0]   rd_ptr,
  output      logic               mem_we,
  output      logic [PTR_W-1:0]   mem_waddr,
  output      logic [ENTRY_W-1:0] mem_wdata,
  output      logic               consume,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      out_item_t          out_data
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               paused_r, paused_nxt;
  logic               flush_r, flush_nxt;
  logic               err_once_r, err_once_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic [ENTRY_W-1:0] held_r, held_nxt;
  logic [7:0]         wait_r, wait_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               step_go;
  logic               attempt;
  logic               tx;
  logic [2:0]         status;
  logic [ENTRY_W-1:0] new_entry;
  logic [ENTRY_W-1:0] head;
  logic [7:0]         flags, hi, lo;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign step_go   = exec_valid && (!out_valid_r || !out_stall);
  assign new_entry = {item.reg_select, item.entry_byte};
  // an enqueue into an empty queue makes the new entry the head
  assign head      = (cnt_r == '0) ? new_entry : head_rdata;

  // framing of the head entry
  always_comb begin
    flags = (head[8] ? RS_FLAG : 8'h00) | (cfg.backlight_on ? BL_FLAG : 8'h00);
    hi    = (head[7:0] & NIB_HI_MASK) | flags;
    lo    = {head[3:0], 4'h0} | flags;
  end

  // one step of the queue
  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    cnt_nxt        = cnt_r;
    paused_nxt     = paused_r;
    flush_nxt      = flush_r;
    err_once_nxt   = err_once_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    wait_nxt       = wait_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_ptr_r;
    mem_wdata      = new_entry;
    attempt        = 1'b0;
    tx             = 1'b0;
    status         = ST_OK;

    if (step_go) begin
      unique case (item.op)
        OP_ENQUEUE: begin
          if (cnt_r == FULL_CNT) begin
            if (paused_r) begin
              status = ST_PAUSED_FULL;
            end else if (held_valid_r) begin
              status = ST_BUSY;
            end else begin
              held_valid_nxt = 1'b1;
              held_nxt       = new_entry;
              wait_nxt       = '0;
              status         = ST_HELD;
            end
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = ptr_inc(wr_ptr_r);
            cnt_nxt    = cnt_r + CNT_W'(1);
            if (item.start_flush && !flush_r && !paused_r) begin
              flush_nxt = 1'b1;
              attempt   = 1'b1;
            end
          end
        end
        OP_DONE: begin
          if (flush_r) begin
            if (paused_r) begin
              flush_nxt = 1'b0;
            end else begin
              attempt = 1'b1;
            end
          end
        end
        OP_PAUSE: begin
          paused_nxt = 1'b1;
        end
        OP_RESUME: begin
          paused_nxt = 1'b0;
          if (!flush_r) begin
            flush_nxt = 1'b1;
            attempt   = 1'b1;
          end
        end
        OP_TICK: begin
          if (held_valid_r) begin
            if (paused_r) begin
              held_valid_nxt = 1'b0;
              held_nxt       = '0;
              wait_nxt       = '0;
              status         = ST_PAUSED_FULL;
            end else if (wait_r >= cfg.full_timeout_ticks) begin
              held_valid_nxt = 1'b0;
              held_nxt       = '0;
              wait_nxt       = '0;
              paused_nxt     = 1'b1;
              status         = ST_TIMEOUT;
            end else begin
              wait_nxt = wait_r + 8'd1;
            end
          end
        end
        OP_ABORT: begin
          flush_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // transfer attempt on the head entry
    if (attempt) begin
      if (cnt_nxt == '0) begin
        flush_nxt = 1'b0;
        status    = ST_EMPTY;
      end else if (item.bus_error && err_once_r) begin
        paused_nxt   = 1'b1;
        err_once_nxt = 1'b0;
        flush_nxt    = 1'b0;
        status       = ST_BUS_ERROR;
      end else begin
        err_once_nxt = item.bus_error;
        if (item.link_refuses) begin
          flush_nxt = 1'b0;
          status    = ST_START_FAIL;
        end else begin
          tx         = 1'b1;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          cnt_nxt    = cnt_nxt - CNT_W'(1);
          // held entry drops into the freed slot
          if (held_valid_r) begin
            mem_we         = 1'b1;
            mem_wdata      = held_r;
            wr_ptr_nxt     = ptr_inc(wr_ptr_r);
            cnt_nxt        = cnt_nxt + CNT_W'(1);
            held_valid_nxt = 1'b0;
            held_nxt       = '0;
            wait_nxt       = '0;
          end
        end
      end
    end
  end

  // result beat assembly
  always_comb begin
    out_data_nxt                       = out_data_r;
    out_valid_nxt                      = out_valid_r && out_stall;
    if (step_go) begin
      out_valid_nxt                      = 1'b1;
      out_data_nxt.status                = status;
      out_data_nxt.tx_start              = tx;
      out_data_nxt.byte_hi_setup         = tx ? hi : 8'h00;
      out_data_nxt.byte_hi_strobe        = tx ? (hi | EN_FLAG) : 8'h00;
      out_data_nxt.byte_hi_hold          = tx ? hi : 8'h00;
      out_data_nxt.byte_lo_setup         = tx ? lo : 8'h00;
      out_data_nxt.byte_lo_strobe        = tx ? (lo | EN_FLAG) : 8'h00;
      out_data_nxt.byte_lo_hold          = tx ? lo : 8'h00;
      out_data_nxt.queue_full            = (cnt_nxt == FULL_CNT);
      out_data_nxt.paused_while_flushing = paused_nxt && flush_nxt;
      out_data_nxt.flushing              = flush_nxt;
      out_data_nxt.entry_count           = 6'(cnt_nxt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
      paused_r     <= 1'b0;
      flush_r      <= 1'b0;
      err_once_r   <= 1'b0;
      held_valid_r <= 1'b0;
      held_r       <= '0;
      wait_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cnt_r        <= cnt_nxt;
      paused_r     <= paused_nxt;
      flush_r      <= flush_nxt;
      err_once_r   <= err_once_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      wait_r       <= wait_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign rd_ptr    = rd_ptr_r;
  assign consume   = step_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench of the lcd nibble command queue
`default_nettype none

module tb_top;
  import lcdq_pkg::*;

  localparam int unsigned DEPTH         = 32;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned PHASE_ITEMS   = 310;

  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  lcd_nibble_command_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // commands waiting for the driver and status beats waiting for the block
  in_item_t    pending_cmds[$];
  out_item_t   replies_due[$];
  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned frames_sent;
  int unsigned status_hits[8];
  int unsigned error_count;
  logic        no_idle;
  logic        in_taken;
  logic        cfg_taken;

  // shadow of the queue state and its registers
  logic [8:0]  q_store[DEPTH];
  int unsigned q_wr;
  int unsigned q_rd;
  int unsigned q_fill;
  logic        q_paused;
  logic        q_chain;
  logic        q_err_once;
  logic        q_hold_valid;
  logic [8:0]  q_hold;
  logic [7:0]  q_hold_ticks;
  logic        bl_set;
  logic [7:0]  timeout_set;

  task automatic reset_shadow();
    q_wr         = 0;
    q_rd         = 0;
    q_fill       = 0;
    q_paused     = 1'b0;
    q_chain      = 1'b0;
    q_err_once   = 1'b0;
    q_hold_valid = 1'b0;
    q_hold       = '0;
    q_hold_ticks = '0;
    bl_set       = BACKLIGHT_RST;
    timeout_set  = TIMEOUT_RST;
  endtask

  task automatic store_entry(input logic [8:0] e);
    q_store[q_wr] = e;
    q_wr = (q_wr + 1) % DEPTH;
    q_fill++;
  endtask

  // one transfer attempt: empty check, bus error filter, refusal, framing
  task automatic try_frame(input logic bus_err, input logic refuses, inout out_item_t res);
    logic [8:0] head;
    logic [7:0] rs;
    logic [7:0] bl;
    logic [7:0] hi;
    logic [7:0] lo;
    if (q_fill == 0) begin
      q_chain = 1'b0;
      res.status = ST_EMPTY;
    end else if (bus_err && q_err_once) begin
      q_paused = 1'b1;
      q_err_once = 1'b0;
      q_chain = 1'b0;
      res.status = ST_BUS_ERROR;
    end else begin
      q_err_once = bus_err;
      if (refuses) begin
        q_chain = 1'b0;
        res.status = ST_START_FAIL;
      end else begin
        head = q_store[q_rd];
        rs = head[8] ? RS_FLAG : 8'h00;
        bl = bl_set ? BL_FLAG : 8'h00;
        hi = (head[7:0] & NIB_HI_MASK) | rs | bl;
        lo = {head[3:0], 4'h0} | rs | bl;
        res.status = ST_OK;
        res.tx_start = 1'b1;
        res.byte_hi_setup = hi;
        res.byte_hi_strobe = hi | EN_FLAG;
        res.byte_hi_hold = hi;
        res.byte_lo_setup = lo;
        res.byte_lo_strobe = lo | EN_FLAG;
        res.byte_lo_hold = lo;
        q_rd = (q_rd + 1) % DEPTH;
        q_fill--;
        // a parked entry takes the freed slot
        if (q_hold_valid) begin
          store_entry(q_hold);
          q_hold_valid = 1'b0;
          q_hold = '0;
          q_hold_ticks = '0;
        end
      end
    end
  endtask

  // next status beat of the queue for one command
  task automatic queue_step(input in_item_t cmd, output out_item_t res);
    res = '0;
    case (cmd.op)
      OP_ENQUEUE: begin
        if (q_fill >= DEPTH) begin
          if (q_paused) begin
            res.status = ST_PAUSED_FULL;
          end else if (q_hold_valid) begin
            res.status = ST_BUSY;
          end else begin
            q_hold_valid = 1'b1;
            q_hold = {cmd.reg_select, cmd.entry_byte};
            q_hold_ticks = '0;
            res.status = ST_HELD;
          end
        end else begin
          store_entry({cmd.reg_select, cmd.entry_byte});
          if (cmd.start_flush && !q_chain && !q_paused) begin
            q_chain = 1'b1;
            try_frame(cmd.bus_error, cmd.link_refuses, res);
          end
        end
      end
      OP_DONE: begin
        if (q_chain) begin
          if (q_paused) q_chain = 1'b0;
          else try_frame(cmd.bus_error, cmd.link_refuses, res);
        end
      end
      OP_PAUSE: q_paused = 1'b1;
      OP_RESUME: begin
        q_paused = 1'b0;
        if (!q_chain) begin
          q_chain = 1'b1;
          try_frame(cmd.bus_error, cmd.link_refuses, res);
        end
      end
      OP_TICK: begin
        if (q_hold_valid) begin
          if (q_paused) begin
            q_hold_valid = 1'b0;
            q_hold = '0;
            q_hold_ticks = '0;
            res.status = ST_PAUSED_FULL;
          end else if (q_hold_ticks >= timeout_set) begin
            q_hold_valid = 1'b0;
            q_hold = '0;
            q_hold_ticks = '0;
            q_paused = 1'b1;
            res.status = ST_TIMEOUT;
          end else begin
            q_hold_ticks = q_hold_ticks + 8'd1;
          end
        end
      end
      OP_ABORT: q_chain = 1'b0;
      default: ;
    endcase
    res.queue_full = (q_fill >= DEPTH);
    res.paused_while_flushing = q_paused && q_chain;
    res.flushing = q_chain;
    res.entry_count = 6'(q_fill);
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic take_gap();
    return !no_idle && roll(IDLE_PCT);
  endfunction

  task automatic add_cmd(input logic [2:0] op, input logic rs, input logic [7:0] value,
                         input logic start, input logic err, input logic refuse);
    in_item_t c;
    c.op = op;
    c.reg_select = rs;
    c.entry_byte = value;
    c.start_flush = start;
    c.bus_error = err;
    c.link_refuses = refuse;
    pending_cmds.push_back(c);
    queued_total++;
  endtask

  task automatic add_rand(input logic [2:0] op, input logic start,
                          input int unsigned err_pct, input int unsigned ref_pct);
    add_cmd(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), start,
            roll(err_pct), roll(ref_pct));
  endtask

  // short write burst followed by the done events that drain it
  task automatic gen_burst();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) add_rand(OP_ENQUEUE, (i == n - 1) || roll(20), 5, 5);
    repeat (n + 1) add_rand(OP_DONE, 1'($urandom_range(0, 1)), 12, 8);
  endtask

  // fill to the brim, park an entry, tick towards the timeout, then drain
  task automatic gen_fill();
    int unsigned extra;
    int unsigned ticks;
    extra = $urandom_range(1, 3);
    ticks = ($urandom_range(0, 3) == 0) ? timeout_set + 1 : $urandom_range(0, 5);
    add_rand(OP_ABORT, 1'b0, 0, 0);
    repeat (DEPTH) add_rand(OP_ENQUEUE, 1'b0, 0, 0);
    if (roll(20)) add_rand(OP_PAUSE, 1'b0, 0, 0);
    repeat (extra) add_rand(OP_ENQUEUE, 1'b0, 0, 0);
    repeat (ticks) add_rand(OP_TICK, 1'b0, 0, 0);
    add_rand(OP_RESUME, 1'b0, 10, 10);
    repeat (DEPTH + 4) add_rand(OP_DONE, 1'b0, 10, 5);
  endtask

  task automatic gen_random(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    target = queued_total + n;
    while (queued_total < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        gen_burst();
      end else if (pick < 68) begin
        gen_fill();
      end else begin
        repeat ($urandom_range(1, 8))
          add_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver: command beats and result stalls change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_cmds.size() != 0 && !take_gap()) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= take_gap();
    end
  end

  // monitor: register writes, accepted commands and result beats
  always @(posedge clk) begin : monitor
    out_item_t pred;
    out_item_t want;
    if (!rst_n) begin
      in_taken  = 1'b0;
      cfg_taken = 1'b0;
    end else begin
      in_taken  = in_valid && !in_stall;
      cfg_taken = cfg_valid && cfg_ready;
      if (cfg_taken) begin
        if (cfg_index == CFG_BACKLIGHT) bl_set = cfg_data[0];
        else if (cfg_index == CFG_TIMEOUT) timeout_set = cfg_data;
      end
      if (in_taken) begin
        queue_step(in_data, pred);
        replies_due.push_back(pred);
        accepted_total++;
        status_hits[pred.status]++;
        if (pred.tx_start) frames_sent++;
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = replies_due.pop_front();
          check_field("status", 8'(out_data.status), 8'(want.status));
          check_field("tx_start", 8'(out_data.tx_start), 8'(want.tx_start));
          check_field("byte_hi_setup", out_data.byte_hi_setup, want.byte_hi_setup);
          check_field("byte_hi_strobe", out_data.byte_hi_strobe, want.byte_hi_strobe);
          check_field("byte_hi_hold", out_data.byte_hi_hold, want.byte_hi_hold);
          check_field("byte_lo_setup", out_data.byte_lo_setup, want.byte_lo_setup);
          check_field("byte_lo_strobe", out_data.byte_lo_strobe, want.byte_lo_strobe);
          check_field("byte_lo_hold", out_data.byte_lo_hold, want.byte_lo_hold);
          check_field("queue_full", 8'(out_data.queue_full), 8'(want.queue_full));
          check_field("paused_while_flushing", 8'(out_data.paused_while_flushing),
                      8'(want.paused_while_flushing));
          check_field("flushing", 8'(out_data.flushing), 8'(want.flushing));
          check_field("entry_count", 8'(out_data.entry_count), 8'(want.entry_count));
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // stimulus phases
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_BACKLIGHT;
    cfg_data       = '0;
    no_idle        = 1'b0;
    in_taken       = 1'b0;
    cfg_taken      = 1'b0;
    queued_total   = 0;
    accepted_total = 0;
    frames_sent    = 0;
    error_count    = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: framing extremes, chain start and end, error filter, pause games
    add_cmd(OP_ENQUEUE, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_ENQUEUE, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_ENQUEUE, 1'b1, 8'h5a, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_RESUME,  1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    add_cmd(OP_RESUME,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
    add_cmd(OP_RESUME,  1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_ENQUEUE, 1'b0, 8'h3c, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_RESUME,  1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
    add_cmd(OP_PAUSE,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_RESUME,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_TICK,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_ABORT,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_SPARE_A, 1'b1, 8'hff, 1'b1, 1'b1, 1'b1);
    add_cmd(OP_SPARE_B, 1'b1, 8'hff, 1'b1, 1'b1, 1'b1);
    add_cmd(OP_ENQUEUE, 1'b1, 8'h81, 1'b1, 1'b1, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
    add_cmd(OP_DONE,    1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    gen_random(PHASE_ITEMS);
    wait_idle();

    // backlight off, zero timeout, no idling on either side
    write_cfg(CFG_BACKLIGHT, 8'd0);
    write_cfg(CFG_TIMEOUT, 8'd0);
    no_idle = 1'b1;
    gen_random(PHASE_ITEMS);
    wait_idle();
    no_idle = 1'b0;

    // backlight on, longest timeout, with a full drain halfway
    write_cfg(CFG_BACKLIGHT, 8'd1);
    write_cfg(CFG_TIMEOUT, 8'd255);
    gen_random(PHASE_ITEMS / 2);
    wait_idle();
    gen_random(PHASE_ITEMS / 2);
    wait_idle();

    write_cfg(CFG_BACKLIGHT, 8'd0);
    write_cfg(CFG_TIMEOUT, 8'd3);
    gen_random(PHASE_ITEMS);
    wait_idle();

    write_cfg(CFG_BACKLIGHT, 8'($urandom_range(0, 1)));
    write_cfg(CFG_TIMEOUT, 8'($urandom_range(1, 254)));
    gen_random(PHASE_ITEMS);
    wait_idle();

    $display("covered %0d commands under five register settings, %0d nibble transfers",
             accepted_total, frames_sent);
    $display("status mix: ok %0d empty %0d paused-full %0d timeout %0d bus-error %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_PAUSED_FULL],
             status_hits[ST_TIMEOUT], status_hits[ST_BUS_ERROR]);
    $display("status mix: start-fail %0d held %0d busy %0d",
             status_hits[ST_START_FAIL], status_hits[ST_HELD], status_hits[ST_BUSY]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
